@@ rtl/gwsp_pkg.sv @@
// ----------------------------------------------------------------------------
// gwsp_pkg
// Shared types, codes and helpers of the grid shortest path block.
// ----------------------------------------------------------------------------
package gwsp_pkg;

  typedef logic [1:0]  kind_t;
  typedef logic [3:0]  digit_t;
  typedef logic [15:0] cost_t;

  localparam kind_t KIND_OPEN  = 2'd0;
  localparam kind_t KIND_WALL  = 2'd1;
  localparam kind_t KIND_START = 2'd2;
  localparam kind_t KIND_GOAL  = 2'd3;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam cost_t COST_NONE = 16'hFFFF;
  localparam cost_t COST_SAT  = 16'hFFFE;

  localparam int CellW = 6;

  function automatic logic [3:0] entry_cost(digit_t digit);
    logic [3:0] cost;
    cost = 4'd1;
    if (digit >= 4'd1 && digit <= 4'd9) begin
      cost = digit + 4'd1;
    end
    return cost;
  endfunction

endpackage

@@ rtl/gwsp_in_if.sv @@
// ----------------------------------------------------------------------------
// gwsp_in_if
// Input channel: one grid cell per word.
// ----------------------------------------------------------------------------
interface gwsp_in_if import gwsp_pkg::*; ();
  logic   valid;
  logic   ready;
  kind_t  cell_kind;
  digit_t cell_digit;
  logic   last_cell;

  modport source(output valid, cell_kind, cell_digit, last_cell, input ready);
  modport sink(input valid, cell_kind, cell_digit, last_cell, output ready);
endinterface

@@ rtl/gwsp_out_if.sv @@
// ----------------------------------------------------------------------------
// gwsp_out_if
// Output channel: one search result per word.
// ----------------------------------------------------------------------------
interface gwsp_out_if import gwsp_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  reachable;
  cost_t path_cost;

  modport source(output valid, reachable, path_cost, input ready);
  modport sink(input valid, reachable, path_cost, output ready);
endinterface

@@ rtl/gwsp_ram.sv @@
// ----------------------------------------------------------------------------
// gwsp_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gwsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/grid_weighted_shortest_path.sv @@
// ----------------------------------------------------------------------------
// grid_weighted_shortest_path
// Loads a grid cell by cell and finds the least entry cost to a goal.
// Loading accepts one cell word per cycle. After the last cell, a setup
// state, a pass that initializes the cost memory for the cells in use,
// then relaxation sweeps, alternating direction, until a sweep changes
// nothing; each cell reads its own cost, then its neighbours' costs, in turn
// through the single cost memory read port. The result word is registered.
// Reset is asynchronous and active low; it clears control state and sets
// both grid dimensions to one.
// ----------------------------------------------------------------------------
module grid_weighted_shortest_path import gwsp_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gwsp_in_if.sink    in_i,
  gwsp_out_if.source out_o,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  localparam int Cells = MAX_ROWS * MAX_COLS;
  localparam int AW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int RCW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [6:0] rows_q, cols_q;
  logic [2:0] state_q, state_d;
  logic [AW-1:0] load_q, load_d, start_q, start_d;
  logic [AW-1:0] idx_q, idx_d, nlast_q, nlast_d, stride_q, stride_d;
  logic [RCW-1:0] r_q, r_d, rlast_q, rlast_d;
  logic [CCW-1:0] c_q, c_d, clast_q, clast_d;
  logic [2:0] step_q, step_d;
  logic fwd_q, fwd_d, changed_q, changed_d, nbok_q, nbok_d;
  cost_t own_q, own_d, nbmin_q, nbmin_d, goal_q, goal_d;
  logic [CellW-1:0] cell_q, cell_d;
  logic res_reach_q, res_reach_d;
  cost_t res_cost_q, res_cost_d;
  logic out_valid_q, out_valid_d;
  logic out_reach_q, out_reach_d;
  cost_t out_cost_q, out_cost_d;

  logic [8:0] rows_eff, cols_eff;
  logic [17:0] cells_in_use;
  logic grid_we, cost_we;
  logic [AW-1:0] cost_raddr, cost_waddr;
  cost_t cost_wdata, cost_rdata;
  logic [CellW-1:0] grid_rdata;
  logic [16:0] cand;
  cost_t cand_sat, new_val;
  logic at_end, cfg_we;

  assign rows_eff = (rows_q == 7'd0) ? 9'd1 :
                    ({2'b0, rows_q} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {2'b0, rows_q};
  assign cols_eff = (cols_q == 7'd0) ? 9'd1 :
                    ({2'b0, cols_q} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {2'b0, cols_q};
  assign cells_in_use = rows_eff * cols_eff;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_COLS) ? {25'b0, cols_q} : {25'b0, rows_q};

  assign in_i.ready      = (state_q == S_LOAD);
  assign out_o.valid     = out_valid_q;
  assign out_o.reachable = out_reach_q;
  assign out_o.path_cost = out_cost_q;

  assign grid_we = in_i.valid && in_i.ready;

  gwsp_ram #(.WIDTH(CellW), .DEPTH(Cells)) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (load_q),
    .wdata_i ({in_i.cell_digit, in_i.cell_kind}),
    .raddr_i (idx_q),
    .rdata_o (grid_rdata)
  );

  gwsp_ram #(.WIDTH(16), .DEPTH(Cells)) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (cost_we),
    .waddr_i (cost_waddr),
    .wdata_i (cost_wdata),
    .raddr_i (cost_raddr),
    .rdata_o (cost_rdata)
  );

  assign cand     = {1'b0, nbmin_q} + {13'b0, entry_cost(cell_q[5:2])};
  assign cand_sat = (cand > {1'b0, COST_SAT}) ? COST_SAT : cand[15:0];
  assign new_val  = (cell_q[1:0] != KIND_WALL && idx_q != start_q &&
                     nbmin_q != COST_NONE && cand_sat < own_q) ? cand_sat : own_q;
  assign at_end   = fwd_q ? (idx_q == nlast_q) : (idx_q == '0);

  always_comb begin
    state_d = state_q;
    load_d = load_q;
    start_d = start_q;
    idx_d = idx_q;
    nlast_d = nlast_q;
    stride_d = stride_q;
    r_d = r_q;
    rlast_d = rlast_q;
    c_d = c_q;
    clast_d = clast_q;
    step_d = step_q;
    fwd_d = fwd_q;
    changed_d = changed_q;
    nbok_d = nbok_q;
    own_d = own_q;
    nbmin_d = nbmin_q;
    goal_d = goal_q;
    cell_d = cell_q;
    res_reach_d = res_reach_q;
    res_cost_d = res_cost_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_reach_d = out_reach_q;
    out_cost_d = out_cost_q;
    cost_we = 1'b0;
    cost_waddr = idx_q;
    cost_wdata = COST_NONE;
    cost_raddr = idx_q;

    case (state_q)
      S_LOAD: begin
        if (grid_we) begin
          if (in_i.cell_kind == KIND_START) begin
            start_d = load_q;
          end
          if (in_i.last_cell) begin
            load_d = '0;
            state_d = S_SETUP;
          end else if (load_q == AW'(Cells - 1)) begin
            load_d = '0;
          end else begin
            load_d = load_q + 1'b1;
          end
        end
      end
      S_SETUP: begin
        nlast_d = AW'(cells_in_use - 18'd1);
        stride_d = AW'(cols_eff);
        rlast_d = RCW'(rows_eff - 9'd1);
        clast_d = CCW'(cols_eff - 9'd1);
        idx_d = '0;
        if ({{(18-AW){1'b0}}, start_q} >= cells_in_use) begin
          res_reach_d = 1'b0;
          res_cost_d = '0;
          state_d = S_DONE;
        end else begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        cost_we = 1'b1;
        cost_wdata = (idx_q == start_q) ? '0 : COST_NONE;
        if (idx_q == nlast_q) begin
          idx_d = '0;
          r_d = '0;
          c_d = '0;
          fwd_d = 1'b1;
          step_d = '0;
          changed_d = 1'b0;
          goal_d = COST_NONE;
          state_d = S_SWEEP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SWEEP: begin
        step_d = step_q + 3'd1;
        if (step_q >= 3'd2 && step_q <= 3'd5) begin
          if (nbok_q && cost_rdata < nbmin_q) begin
            nbmin_d = cost_rdata;
          end
        end
        case (step_q)
          3'd0: begin
            cost_raddr = idx_q;
          end
          3'd1: begin
            own_d = cost_rdata;
            cell_d = grid_rdata;
            nbmin_d = COST_NONE;
            cost_raddr = idx_q - 1'b1;
            nbok_d = (c_q != '0);
          end
          3'd2: begin
            cost_raddr = idx_q + 1'b1;
            nbok_d = (c_q != clast_q);
          end
          3'd3: begin
            cost_raddr = idx_q - stride_q;
            nbok_d = (r_q != '0);
          end
          3'd4: begin
            cost_raddr = idx_q + stride_q;
            nbok_d = (r_q != rlast_q);
          end
          3'd5: begin
            nbok_d = 1'b0;
          end
          default: begin
            step_d = '0;
            cost_we = (new_val != own_q);
            cost_wdata = new_val;
            if (cell_q[1:0] == KIND_GOAL && new_val < goal_q) begin
              goal_d = new_val;
            end
            if (at_end) begin
              if (changed_q || new_val != own_q) begin
                changed_d = 1'b0;
                goal_d = COST_NONE;
                fwd_d = !fwd_q;
                if (fwd_q) begin
                  idx_d = nlast_q;
                  r_d = rlast_q;
                  c_d = clast_q;
                end else begin
                  idx_d = '0;
                  r_d = '0;
                  c_d = '0;
                end
              end else begin
                res_reach_d = (goal_d != COST_NONE);
                res_cost_d = (goal_d != COST_NONE) ? goal_d : '0;
                state_d = S_DONE;
              end
            end else begin
              if (new_val != own_q) begin
                changed_d = 1'b1;
              end
              if (fwd_q) begin
                idx_d = idx_q + 1'b1;
                if (c_q == clast_q) begin
                  c_d = '0;
                  r_d = r_q + 1'b1;
                end else begin
                  c_d = c_q + 1'b1;
                end
              end else begin
                idx_d = idx_q - 1'b1;
                if (c_q == '0) begin
                  c_d = clast_q;
                  r_d = r_q - 1'b1;
                end else begin
                  c_d = c_q - 1'b1;
                end
              end
            end
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_reach_d = res_reach_q;
          out_cost_d = res_cost_q;
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      load_q <= '0;
      start_q <= '0;
      out_valid_q <= 1'b0;
      rows_q <= 7'd1;
      cols_q <= 7'd1;
      step_q <= '0;
      fwd_q <= 1'b1;
      changed_q <= 1'b0;
      nbok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      load_q <= load_d;
      start_q <= start_d;
      out_valid_q <= out_valid_d;
      step_q <= step_d;
      fwd_q <= fwd_d;
      changed_q <= changed_d;
      nbok_q <= nbok_d;
      if (cfg_we && paddr[2] == REG_ROWS) begin
        rows_q <= pwdata[6:0];
      end
      if (cfg_we && paddr[2] == REG_COLS) begin
        cols_q <= pwdata[6:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    nlast_q <= nlast_d;
    stride_q <= stride_d;
    r_q <= r_d;
    rlast_q <= rlast_d;
    c_q <= c_d;
    clast_q <= clast_d;
    own_q <= own_d;
    nbmin_q <= nbmin_d;
    goal_q <= goal_d;
    cell_q <= cell_d;
    res_reach_q <= res_reach_d;
    res_cost_q <= res_cost_d;
    out_reach_q <= out_reach_d;
    out_cost_q <= out_cost_d;
  end

endmodule
